FILE: design/tree_leaf_count_per_level_assert.svh
// Assertion macros for the RTL of the leaf counter.
`ifndef TREE_LEAF_COUNT_PER_LEVEL_ASSERT_SVH
`define TREE_LEAF_COUNT_PER_LEVEL_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define TLCPL_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TLCPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLCPL_ASSERT(label, ante, cons, msg)
`define TLCPL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/tlcpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlcpl_pkg;

  localparam int ID_PORT_W = 6;
  localparam int RES_W     = 7;
  localparam int PC_W      = 4;

  // Operation codes of an input word.
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_COUNT = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  // Microprogram step addresses.
  localparam pc_t S_IN       = 4'd0;
  localparam pc_t S_DISPATCH = 4'd1;
  localparam pc_t S_EDGE_RD  = 4'd2;
  localparam pc_t S_EDGE_WR  = 4'd3;
  localparam pc_t S_INIT     = 4'd4;
  localparam pc_t S_POP      = 4'd5;
  localparam pc_t S_FETCH    = 4'd6;
  localparam pc_t S_LVL      = 4'd7;
  localparam pc_t S_EMIT     = 4'd8;
  localparam pc_t S_TALLY    = 4'd9;
  localparam pc_t S_CHILD    = 4'd10;
  localparam pc_t S_SIB      = 4'd11;
  localparam pc_t S_FINAL    = 4'd12;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_OP_COUNT,
    C_BAD,
    C_Q_EMPTY,
    C_LVL_SAME,
    C_CHILD_DONE
  } cond_t;

  typedef struct packed {
    logic  hold_in;
    logic  hold_out;
    logic  fc_rd_par;
    logic  edge_wr;
    logic  init;
    logic  q_rd;
    logic  fc_rd_node;
    logic  take_child;
    logic  child_push;
    logic  sib_load;
    logic  emit;
    logic  emit_last;
    logic  clr;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // Control store: the jump is taken when the condition holds, else the
  // step counter advances by one.
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t w;
    w = '0;
    w.cond = C_NEXT;
    w.target = S_IN;
    unique case (pc)
      S_IN: begin
        w.hold_in = 1'b1;
      end
      S_DISPATCH: begin
        w.cond = C_OP_COUNT;
        w.target = S_INIT;
      end
      S_EDGE_RD: begin
        w.fc_rd_par = 1'b1;
        w.cond = C_BAD;
        w.target = S_IN;
      end
      S_EDGE_WR: begin
        w.edge_wr = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_IN;
      end
      S_INIT: begin
        w.init = 1'b1;
      end
      S_POP: begin
        w.q_rd = 1'b1;
        w.cond = C_Q_EMPTY;
        w.target = S_FINAL;
      end
      S_FETCH: begin
        w.fc_rd_node = 1'b1;
      end
      S_LVL: begin
        w.cond = C_LVL_SAME;
        w.target = S_TALLY;
      end
      S_EMIT: begin
        w.hold_out = 1'b1;
        w.emit = 1'b1;
      end
      S_TALLY: begin
        w.take_child = 1'b1;
      end
      S_CHILD: begin
        w.child_push = 1'b1;
        w.cond = C_CHILD_DONE;
        w.target = S_POP;
      end
      S_SIB: begin
        w.sib_load = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_CHILD;
      end
      S_FINAL: begin
        w.hold_out = 1'b1;
        w.emit = 1'b1;
        w.emit_last = 1'b1;
        w.clr = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_IN;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = S_IN;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/tree_leaf_count_per_level.sv
// Breadth-first leaf counter for a rooted tree.
// Input channel (in_valid/in_ready): each word is either an edge
// (operation 0, parent_id, child_id) or a count command (operation 1).
// Edges with an id of zero or not below MAX_NODES are dropped. A word is
// taken only while the microsequencer sits at its fetch step.
// After an edge is accepted, the sequencer does one first-child table
// read, then the two table writes, before the next word can be taken.
// A count command walks the tree from node 1 and sends one output word per
// level (leaf_count, level_number, last set on the deepest level). Each node
// passes the pop, fetch, level, tally and child steps, plus a queue write
// and a next-sibling read per child enqueued and an emit step per level
// change. Throughput is set by the single-port sequencing through the
// table and queue memories.
// The output word sits in a register; while the receiver stalls the
// sequencer waits at its emit step. Edges may be loaded while the final word
// of a count is still waiting.
// After a count the tables read as empty again at once (valid bits cleared).
// Reset (synchronous) empties the tables and returns to the fetch step; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_leaf_count_per_level_assert.svh"

module tree_leaf_count_per_level
  import tlcpl_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 operation,
  input  wire logic [ID_PORT_W-1:0] parent_id,
  input  wire logic [ID_PORT_W-1:0] child_id,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [RES_W-1:0]     leaf_count,
  output logic      [RES_W-1:0]     level_number,
  output logic                      last
);

  localparam int ID_W  = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int QW    = ID_W + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  pc_t  pc;
  pc_t  pc_next;
  ctl_t ctl;
  logic go;
  logic jump;
  logic out_free;
  logic emit_fire;

  logic                 op_reg;
  logic [ID_PORT_W-1:0] par_reg;
  logic [ID_PORT_W-1:0] chi_reg;
  logic                 bad;

  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] tail;
  logic [CNT_W-1:0] cur_level;
  logic [CNT_W-1:0] tally;
  logic [CNT_W-1:0] lvl_reg;
  logic [ID_W-1:0]  c_reg;
  logic             q_empty;
  logic             child_done;

  logic [MAX_NODES-1:0] fc_vld;
  logic [MAX_NODES-1:0] ns_vld;
  logic                 fc_vld_q;
  logic                 ns_vld_q;

  logic            fc_rd;
  logic [ID_W-1:0] fc_addr;
  logic [ID_W-1:0] fc_q;
  logic [ID_W-1:0] fc_eff;
  logic            fc_wr;
  logic            ns_rd;
  logic [ID_W-1:0] ns_q;
  logic [ID_W-1:0] ns_eff;
  logic            q_wr;
  logic            q_rd;
  logic [ID_W-1:0] q_waddr;
  logic [QW-1:0]   q_wdata;
  logic [QW-1:0]   q_rdata;
  logic [ID_W-1:0] q_node;
  logic [CNT_W-1:0] q_lvl;
  logic            push;

  // Sequencer.
  assign ctl      = ucode(pc);
  assign in_ready = ctl.hold_in;
  assign out_free = !out_valid || out_ready;
  assign go       = (!ctl.hold_in || in_valid) && (!ctl.hold_out || out_free);
  assign emit_fire = ctl.emit && go;

  assign bad = (par_reg == '0) || (chi_reg == '0) ||
               ({1'b0, par_reg} >= RES_W'(MAX_NODES)) ||
               ({1'b0, chi_reg} >= RES_W'(MAX_NODES));
  assign q_empty    = (head == tail);
  assign child_done = (c_reg == '0) || (tail == MAX_CNT);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_OP_COUNT:   jump = (op_reg == OP_COUNT);
      C_BAD:        jump = bad;
      C_Q_EMPTY:    jump = q_empty;
      C_LVL_SAME:   jump = (lvl_reg == cur_level);
      C_CHILD_DONE: jump = child_done;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Memory ports. Table entries never written since the last count read as
  // zero through the valid bits.
  assign fc_eff = fc_vld_q ? fc_q : '0;
  assign ns_eff = ns_vld_q ? ns_q : '0;
  assign q_node = q_rdata[QW-1:CNT_W];
  assign q_lvl  = q_rdata[CNT_W-1:0];

  assign fc_rd   = go && ((ctl.fc_rd_par && !bad) || ctl.fc_rd_node);
  assign fc_addr = ctl.fc_rd_node ? q_node : par_reg[ID_W-1:0];
  assign fc_wr   = go && ctl.edge_wr;
  assign push    = go && ctl.child_push && !child_done;
  assign ns_rd   = push;
  assign q_rd    = go && ctl.q_rd && !q_empty;
  assign q_wr    = (go && ctl.init) || push;
  assign q_waddr = ctl.init ? '0 : tail[ID_W-1:0];
  assign q_wdata = ctl.init ? {ID_W'(1), CNT_W'(1)} : {c_reg, lvl_reg + CNT_W'(1)};

  tlcpl_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_fc_ram (
    .clk     (clk),
    .wr_en   (fc_wr),
    .wr_addr (par_reg[ID_W-1:0]),
    .wr_data (chi_reg[ID_W-1:0]),
    .rd_en   (fc_rd),
    .rd_addr (fc_addr),
    .rd_data (fc_q)
  );

  tlcpl_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_ns_ram (
    .clk     (clk),
    .wr_en   (fc_wr),
    .wr_addr (chi_reg[ID_W-1:0]),
    .wr_data (fc_eff),
    .rd_en   (ns_rd),
    .rd_addr (c_reg),
    .rd_data (ns_q)
  );

  tlcpl_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_q_ram (
    .clk     (clk),
    .wr_en   (q_wr),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_addr (head[ID_W-1:0]),
    .rd_data (q_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_IN;
      fc_vld    <= '0;
      ns_vld    <= '0;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      cur_level <= CNT_W'(1);
      tally     <= '0;
    end else begin
      pc <= pc_next;
      if (fc_wr) begin
        fc_vld[par_reg[ID_W-1:0]] <= 1'b1;
        ns_vld[chi_reg[ID_W-1:0]] <= 1'b1;
      end
      if (go && ctl.clr) begin
        fc_vld <= '0;
        ns_vld <= '0;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go && ctl.init) begin
        head      <= '0;
        tail      <= CNT_W'(1);
        cur_level <= CNT_W'(1);
        tally     <= '0;
      end
      if (q_rd) begin
        head <= head + CNT_W'(1);
      end
      if (push) begin
        tail <= tail + CNT_W'(1);
      end
      if (emit_fire && !ctl.emit_last) begin
        cur_level <= cur_level + CNT_W'(1);
        tally     <= '0;
      end
      if (go && ctl.take_child && (fc_eff == '0)) begin
        tally <= tally + CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_reg  <= operation;
      par_reg <= parent_id;
      chi_reg <= child_id;
    end
    if (fc_rd) begin
      fc_vld_q <= fc_vld[fc_addr];
    end
    if (ns_rd) begin
      ns_vld_q <= ns_vld[c_reg];
    end
    if (go && ctl.fc_rd_node) begin
      lvl_reg <= q_lvl;
    end
    if (go && ctl.take_child) begin
      c_reg <= fc_eff;
    end
    if (go && ctl.sib_load) begin
      c_reg <= ns_eff;
    end
    if (emit_fire) begin
      leaf_count   <= RES_W'(tally);
      level_number <= RES_W'(cur_level);
      last         <= ctl.emit_last;
    end
  end

  `TLCPL_ASSERT(a_head_le_tail, 1'b1, head <= tail, "queue head passed tail")
  `TLCPL_ASSERT(a_tail_bound, 1'b1, tail <= MAX_CNT, "queue tail beyond depth")
  `TLCPL_ASSERT(a_emit_free, emit_fire, !out_valid || out_ready, "output word overwritten")
  `TLCPL_ASSERT_NEXT(a_clear_after_count, emit_fire && ctl.emit_last, (fc_vld == '0) && (ns_vld == '0), "tables not cleared after count")

endmodule

`default_nettype wire

FILE: design/tlcpl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tlcpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // The read word holds until the next read.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: dv/tlcpl_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the leaf counter, keeps its own copy of the child
// and sibling tables, and predicts the per-level words of every count command.
module tlcpl_checker
  import tlcpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 operation,
  input  logic [ID_PORT_W-1:0] parent_id,
  input  logic [ID_PORT_W-1:0] child_id,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [RES_W-1:0]     leaf_count,
  input  logic [RES_W-1:0]     level_number,
  input  logic                 last,
  output int                   mismatch_count,
  output int                   levels_pending
);

  localparam int NODES = 64;

  typedef struct packed {
    logic [RES_W-1:0] count;
    logic [RES_W-1:0] level;
    logic             last;
  } level_word_t;

  level_word_t level_q[$];
  logic [ID_PORT_W-1:0] first_child [NODES];
  logic [ID_PORT_W-1:0] next_sibling [NODES];
  int bad_words = 0;
  int words_seen = 0;

  // Breadth-first walk from node 1. The walk list is capped at NODES entries,
  // so cyclic or shared children still terminate; a node reached twice is
  // counted twice.
  task automatic count_levels();
    logic [ID_PORT_W-1:0] bfs_node [NODES];
    logic [RES_W-1:0]     bfs_level [NODES];
    logic [ID_PORT_W-1:0] node;
    logic [ID_PORT_W-1:0] kid;
    logic [RES_W-1:0]     lvl;
    logic [RES_W-1:0]     cur_level;
    logic [RES_W-1:0]     tally;
    int head;
    int tail;
    int steps;
    head = 0;
    tail = 1;
    bfs_node[0] = 1;
    bfs_level[0] = 1;
    cur_level = 1;
    tally = 0;
    while (head < tail) begin
      node = bfs_node[head];
      lvl = bfs_level[head];
      head++;
      if (lvl != cur_level) begin
        level_q.push_back({tally, cur_level, 1'b0});
        cur_level++;
        tally = 0;
      end
      if (first_child[node] == 0) tally++;
      kid = first_child[node];
      steps = 0;
      while (kid != 0 && steps < NODES && tail < NODES) begin
        bfs_node[tail] = kid;
        bfs_level[tail] = lvl + 7'd1;
        tail++;
        kid = next_sibling[kid];
        steps++;
      end
    end
    level_q.push_back({tally, cur_level, 1'b1});
    for (int i = 0; i < NODES; i++) begin
      first_child[i] = '0;
      next_sibling[i] = '0;
    end
  endtask

  task automatic flag_word(input level_word_t want, input level_word_t seen, input bit orphan);
    bad_words++;
    if (bad_words <= 10) begin
      if (orphan)
        $display("%0t: output word %0d arrived with none predicted: count %0d level %0d last %0d",
                 $time, words_seen, seen.count, seen.level, seen.last);
      else
        $display("%0t: output word %0d expected count %0d level %0d last %0d, got %0d %0d %0d",
                 $time, words_seen, want.count, want.level, want.last,
                 seen.count, seen.level, seen.last);
    end
  endtask

  always @(posedge clk) begin
    level_word_t seen;
    level_word_t want;
    if (rst) begin
      level_q.delete();
      for (int i = 0; i < NODES; i++) begin
        first_child[i] = '0;
        next_sibling[i] = '0;
      end
    end else begin
      // Output first: a word leaving at this edge can never belong to a
      // command accepted at the same edge.
      if (out_valid && out_ready) begin
        seen = {leaf_count, level_number, last};
        if (level_q.size() == 0) begin
          flag_word(seen, seen, 1'b1);
        end else begin
          want = level_q.pop_front();
          if (seen !== want) flag_word(want, seen, 1'b0);
        end
        words_seen++;
      end
      if (in_valid && in_ready) begin
        if (operation == OP_COUNT) begin
          count_levels();
        end else if (parent_id != 0 && child_id != 0) begin
          next_sibling[child_id] = first_child[parent_id];
          first_child[parent_id] = child_id;
        end
      end
    end
    mismatch_count <= bad_words;
    levels_pending <= level_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import tlcpl_pkg::*;
();

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 operation = OP_EDGE;
  logic [ID_PORT_W-1:0] parent_id = '0;
  logic [ID_PORT_W-1:0] child_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RES_W-1:0]     leaf_count;
  logic [RES_W-1:0]     level_number;
  logic                 last;
  int                   mismatch_count;
  int                   levels_pending;

  int words_sent = 0;
  bit calm = 1'b0;

  tree_leaf_count_per_level u_top (.*);
  tlcpl_checker u_checker (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small ids make repeats and cycles likely; a few come from the full range.
  function automatic logic [ID_PORT_W-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return ID_PORT_W'($urandom_range(0, 63));
    return ID_PORT_W'($urandom_range(1, 8));
  endfunction

  // Entered and left at a falling edge. Valid stays high after acceptance;
  // the next call or a sender pause decides what happens to it.
  task automatic send_word(input logic op, input logic [ID_PORT_W-1:0] par,
                           input logic [ID_PORT_W-1:0] chi);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    parent_id <= par;
    child_id <= chi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_COUNT || (par != 0 && chi != 0)) words_sent++;
    @(negedge clk);
  endtask

  task automatic hold_sender();
    in_valid <= 1'b0;
    @(negedge clk);
    while (levels_pending != 0) @(negedge clk);
  endtask

  // A proper tree of n distinct ids rooted at node 1, edges in random order.
  task automatic send_tree(input int n);
    logic [ID_PORT_W-1:0] pool [62];
    logic [ID_PORT_W-1:0] members [63];
    logic [ID_PORT_W-1:0] edge_par [62];
    logic [ID_PORT_W-1:0] edge_chi [62];
    logic [ID_PORT_W-1:0] tmp;
    int j;
    int left;
    for (int k = 0; k < 62; k++) pool[k] = ID_PORT_W'(k + 2);
    for (int k = 0; k < n - 1; k++) begin
      j = $urandom_range(k, 61);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    members[0] = 1;
    for (int k = 1; k < n; k++) begin
      members[k] = pool[k-1];
      edge_par[k-1] = members[$urandom_range(0, k - 1)];
      edge_chi[k-1] = members[k];
    end
    left = n - 1;
    while (left > 0) begin
      j = $urandom_range(0, left - 1);
      send_word(OP_EDGE, edge_par[j], edge_chi[j]);
      edge_par[j] = edge_par[left-1];
      edge_chi[j] = edge_chi[left-1];
      left--;
    end
    send_word(OP_COUNT, ID_PORT_W'($urandom_range(0, 63)), ID_PORT_W'($urandom_range(0, 63)));
  endtask

  // Loose edges with repeats, cycles and zero ids, an occasional early count.
  task automatic send_noise();
    int m;
    m = $urandom_range(1, 16);
    repeat (m) begin
      send_word(($urandom_range(0, 11) == 0) ? OP_COUNT : OP_EDGE, pick_id(), pick_id());
    end
    send_word(OP_COUNT, ID_PORT_W'($urandom_range(0, 63)), ID_PORT_W'($urandom_range(0, 63)));
  endtask

  initial begin
    int stall;
    @(negedge rst);
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int sets;
    int size;
    sets = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Root alone; the count ignores its id fields.
    send_word(OP_COUNT, 6'd63, 6'd63);
    // Widest ids in a three-level chain.
    send_word(OP_EDGE, 6'd1, 6'd63);
    send_word(OP_EDGE, 6'd63, 6'd2);
    send_word(OP_COUNT, 6'd0, 6'd0);
    // Zero ids are dropped.
    send_word(OP_EDGE, 6'd0, 6'd5);
    send_word(OP_EDGE, 6'd5, 6'd0);
    send_word(OP_EDGE, 6'd0, 6'd0);
    send_word(OP_EDGE, 6'd1, 6'd5);
    send_word(OP_COUNT, 6'd42, 6'd21);
    // Root as its own child fills the walk list: the deepest possible result.
    send_word(OP_EDGE, 6'd1, 6'd1);
    send_word(OP_COUNT, 6'd0, 6'd0);
    // Repeated parent, a child shared by two parents, and a detached edge.
    send_word(OP_EDGE, 6'd1, 6'd2);
    send_word(OP_EDGE, 6'd1, 6'd3);
    send_word(OP_EDGE, 6'd1, 6'd4);
    send_word(OP_EDGE, 6'd2, 6'd5);
    send_word(OP_EDGE, 6'd3, 6'd5);
    send_word(OP_EDGE, 6'd40, 6'd41);
    send_word(OP_COUNT, 6'd63, 6'd0);
    // The same edge twice loops the sibling list.
    send_word(OP_EDGE, 6'd1, 6'd2);
    send_word(OP_EDGE, 6'd1, 6'd3);
    send_word(OP_EDGE, 6'd1, 6'd2);
    send_word(OP_COUNT, 6'd0, 6'd63);

    while (words_sent < 430) begin
      calm = ($urandom_range(0, 6) == 0);
      if (sets == 4 || $urandom_range(0, 19) == 0) hold_sender();
      if ($urandom_range(0, 9) < 7) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 63) : $urandom_range(1, 10);
        send_tree(size);
      end else begin
        send_noise();
      end
      sets++;
    end

    hold_sender();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && levels_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
